/* sv/best_bridge_state_select_core_assert.svh */
// assertion macros used by the bridge state select controller
`ifndef BEST_BRIDGE_STATE_SELECT_CORE_ASSERT_SVH
`define BEST_BRIDGE_STATE_SELECT_CORE_ASSERT_SVH

// property checked at every rising edge outside of reset
`define BBSS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bbss assertion failed");

// condition that must never hold outside of reset
`define BBSS_ASSERT_NEVER(name, clk, rst_n, cond) \
  `BBSS_ASSERT(name, clk, rst_n, !(cond))

`endif

/* sv/bbss_pkg.sv */
`timescale 1ns / 1ps

package bbss_pkg;

  // fixed field widths
  localparam int STATE_W   = 5;
  localparam int PROB_W    = 16;
  localparam int SCORE_W   = 32;
  localparam int OUTCOME_W = 3;

  // parameter defaults
  localparam int NUM_STATES_DEF  = 32;
  localparam int MAX_ENTRIES_DEF = 8;
  localparam int WEIGHT_BITS_DEF = 16;

  // function codes
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_CHOSEN   = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FALLBACK = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_ORIGIN   = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_APPENDED = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd4;

  // input transaction
  typedef struct packed {
    logic               func;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [PROB_W-1:0]  probability;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [STATE_W-1:0]   chosen_state;
    logic [OUTCOME_W-1:0] outcome;
    logic [SCORE_W-1:0]   best_score;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic                 load;       // latch the input item
    logic                 wr_entry;   // append entry to origin list
    logic                 start_q;    // begin a query: latch count, clear best
    logic                 rd_en;      // table read
    logic                 rd_inner;   // read from candidate list, else origin list
    logic                 cnt_cand;   // count lookup by read target, else by origin
    logic                 take_cand;  // latch candidate from read data
    logic                 ld_wb;      // latch second weight (hit or zero)
    logic                 mul;        // form score product
    logic                 cmp;        // compare score, advance candidate
    logic                 emit;       // present a result
    logic [OUTCOME_W-1:0] res_code;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic func;
    logic from_ok;
    logic cnt_zero;
    logic cnt_full;
    logic k_last;
    logic j_end;
    logic hit;
    logic best_zero;
  } dp_sts_t;

endpackage

/* sv/bbss_ctrl.sv */
`timescale 1ns / 1ps

`include "best_bridge_state_select_core_assert.svh"

module bbss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bbss_pkg::dp_sts_t sts_i,
  output bbss_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_RD_OUT   = 3'd2;
  localparam logic [2:0] S_GET_CAND = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_MUL      = 3'd5;
  localparam logic [2:0] S_CMP      = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // sequencing and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.func == bbss_pkg::FUNC_APPEND) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.from_ok || sts_i.cnt_full) begin
            cmd_o.res_code = bbss_pkg::OUT_FULL;
          end else begin
            cmd_o.wr_entry = 1'b1;
            cmd_o.res_code = bbss_pkg::OUT_APPENDED;
          end
          state_d = S_IDLE;
        end else if (!sts_i.from_ok || sts_i.cnt_zero) begin
          cmd_o.emit     = 1'b1;
          cmd_o.res_code = bbss_pkg::OUT_FALLBACK;
          state_d        = S_IDLE;
        end else begin
          cmd_o.start_q = 1'b1;
          state_d       = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_GET_CAND;
      end
      S_GET_CAND: begin
        cmd_o.cnt_cand  = 1'b1;
        cmd_o.take_cand = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        // one read issued per cycle, previous read checked against the destination
        if (sts_i.hit || sts_i.j_end) begin
          cmd_o.ld_wb = 1'b1;
          state_d     = S_MUL;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_inner = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.k_last ? S_FINISH : S_RD_OUT;
      end
      S_FINISH: begin
        cmd_o.emit     = 1'b1;
        cmd_o.res_code = sts_i.best_zero ? bbss_pkg::OUT_ORIGIN : bbss_pkg::OUT_CHOSEN;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `BBSS_ASSERT(a_emit_then_idle, clk_i, rst_ni, cmd_o.emit |=> state_q == S_IDLE)
  `BBSS_ASSERT(a_load_when_idle, clk_i, rst_ni, cmd_o.load |-> state_q == S_IDLE)
  `BBSS_ASSERT(a_mul_then_cmp, clk_i, rst_ni, cmd_o.mul |=> cmd_o.cmp)
  `BBSS_ASSERT_NEVER(a_no_write_full, clk_i, rst_ni,
                     cmd_o.wr_entry && (!sts_i.from_ok || sts_i.cnt_full))

endmodule

/* sv/bbss_dp.sv */
`timescale 1ns / 1ps

module bbss_dp #(
  parameter int NUM_STATES  = bbss_pkg::NUM_STATES_DEF,
  parameter int MAX_ENTRIES = bbss_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = bbss_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bbss_pkg::STATE_W-1:0] cfg_wdata_i,
  input  bbss_pkg::in_item_t           item_i,
  input  bbss_pkg::dp_cmd_t            cmd_i,
  output bbss_pkg::dp_sts_t            sts_o,
  output logic                         done_o,
  output bbss_pkg::out_item_t          result_o
);

  localparam int SW    = bbss_pkg::STATE_W;
  localparam int DEPTH = NUM_STATES * MAX_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(NUM_STATES);
  localparam int KW    = $clog2(MAX_ENTRIES + 1);
  localparam int EW    = SW + WEIGHT_BITS;
  localparam int PW    = 2 * WEIGHT_BITS;

  bbss_pkg::in_item_t  item_q;
  bbss_pkg::out_item_t res_q;
  logic                done_q;
  logic [SW-1:0]       fb_q;

  logic [EW-1:0]          mem_q [DEPTH];
  logic [EW-1:0]          rdata_q;
  logic [KW-1:0]          cnt_q [NUM_STATES];
  logic [KW-1:0]          n_q, k_q, m_q, j_q;
  logic                   rv_q, have_q;
  logic [SW-1:0]          cand_q, bst_state_q;
  logic [WEIGHT_BITS-1:0] wa_q, wb_q;
  logic [PW-1:0]          prod_q, best_q;

  logic [SW-1:0]          rd_target;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [SW-1:0]          cnt_state;
  logic                   cnt_ok;
  logic [IW-1:0]          cnt_idx;
  logic [KW-1:0]          cnt_rd;
  logic                   from_ok;
  logic [AW-1:0]          raddr, waddr;

  assign rd_target = rdata_q[EW-1 -: SW];
  assign rd_weight = rdata_q[WEIGHT_BITS-1:0];

  // range check of origin
  assign from_ok = (32'(item_q.from_state) < 32'(NUM_STATES));

  // entry count lookup, by origin or by candidate just read
  assign cnt_state = cmd_i.cnt_cand ? rd_target : item_q.from_state;
  assign cnt_ok    = (32'(cnt_state) < 32'(NUM_STATES));
  assign cnt_idx   = IW'(cnt_state);
  assign cnt_rd    = cnt_ok ? cnt_q[cnt_idx] : '0;

  // table addresses
  assign waddr = AW'(IW'(item_q.from_state)) * AW'(MAX_ENTRIES) + AW'(cnt_rd);
  assign raddr = cmd_i.rd_inner ? AW'(IW'(cand_q)) * AW'(MAX_ENTRIES) + AW'(j_q)
                                : AW'(IW'(item_q.from_state)) * AW'(MAX_ENTRIES) + AW'(k_q);

  // status
  always_comb begin
    sts_o.func      = item_q.func;
    sts_o.from_ok   = from_ok;
    sts_o.cnt_zero  = (cnt_rd == '0);
    sts_o.cnt_full  = (cnt_rd == KW'(MAX_ENTRIES));
    sts_o.k_last    = ((KW + 1)'(k_q) + (KW + 1)'(1) == (KW + 1)'(n_q));
    sts_o.j_end     = (j_q == m_q);
    sts_o.hit       = rv_q && (rd_target == item_q.to_state);
    sts_o.best_zero = (best_q == '0);
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= '0;
    end else if (cfg_we_i) begin
      fb_q <= cfg_wdata_i;
    end
  end

  // entry counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.wr_entry) begin
      cnt_q[cnt_idx] <= cnt_rd + KW'(1);
    end
  end

  // entry table, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      mem_q[waddr] <= {item_q.to_state, WEIGHT_BITS'(item_q.probability)};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q   <= 1'b0;
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rv_q   <= cmd_i.rd_en && cmd_i.rd_inner;
      done_q <= cmd_i.emit;
      if (cmd_i.start_q) begin
        have_q <= 1'b0;
      end else if (cmd_i.cmp) begin
        have_q <= 1'b1;
      end
    end
  end

  // query walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.start_q) begin
      n_q    <= cnt_rd;
      k_q    <= '0;
      best_q <= '0;
    end
    if (cmd_i.take_cand) begin
      cand_q <= rd_target;
      wa_q   <= rd_weight;
      m_q    <= cnt_rd;
      j_q    <= '0;
    end else if (cmd_i.rd_en && cmd_i.rd_inner) begin
      j_q <= j_q + KW'(1);
    end
    if (cmd_i.ld_wb) begin
      wb_q <= sts_o.hit ? rd_weight : '0;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(wa_q) * PW'(wb_q);
    end
    if (cmd_i.cmp) begin
      k_q <= k_q + KW'(1);
      // first strict maximum wins
      if (!have_q || prod_q > best_q) begin
        best_q      <= prod_q;
        bst_state_q <= cand_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.outcome <= cmd_i.res_code;
      case (cmd_i.res_code)
        bbss_pkg::OUT_FALLBACK: begin
          res_q.chosen_state <= fb_q;
          res_q.best_score   <= '0;
        end
        bbss_pkg::OUT_ORIGIN: begin
          res_q.chosen_state <= item_q.from_state;
          res_q.best_score   <= '0;
        end
        bbss_pkg::OUT_CHOSEN: begin
          res_q.chosen_state <= bst_state_q;
          res_q.best_score   <= bbss_pkg::SCORE_W'(best_q);
        end
        default: begin
          res_q.chosen_state <= '0;
          res_q.best_score   <= '0;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* sv/best_bridge_state_select_core.sv */
`timescale 1ns / 1ps

// Best bridge state select. Holds, per state, an ordered list of up to MAX_ENTRIES
// (target, weight) entries. A transaction is taken when start is high and busy is
// low; its single result appears on result_o while done_o is high for exactly one
// cycle, and must be captured then, since the receiver cannot stall the block.
// One transaction is worked at a time. An append, or a query whose origin has no
// entries or is out of range, is settled in the decode state, which loads the result
// register and done_o. A query walks the origin's n candidates through the single
// table read port; for each it reads the origin entry, takes the candidate, then
// reads that candidate's list until the destination is found or the list ends (at
// most its count), then forms the score and compares it with the best. A finish
// state then emits the result. One score multiplier serves every candidate.
// Entry counts clear on reset at once; entry contents are undefined until appended.
// fallback_state is written through cfg_we_i / cfg_wdata_i and resets to zero.
module best_bridge_state_select_core #(
  parameter int NUM_STATES  = bbss_pkg::NUM_STATES_DEF,
  parameter int MAX_ENTRIES = bbss_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = bbss_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bbss_pkg::STATE_W-1:0] cfg_wdata_i,
  input  logic                         start,
  input  bbss_pkg::in_item_t           item_i,
  output logic                         busy,
  output logic                         done_o,
  output bbss_pkg::out_item_t          result_o
);

  bbss_pkg::dp_cmd_t cmd;
  bbss_pkg::dp_sts_t sts;

  // sequencer
  bbss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // table, scoring and result registers
  bbss_dp #(
    .NUM_STATES  (NUM_STATES),
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_ST        = bbss_pkg::NUM_STATES_DEF;
  localparam int MAX_ENT       = bbss_pkg::MAX_ENTRIES_DEF;
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 270;
  localparam int POOL_HI       = 11;
  localparam int SETTLE_CYCLES = 120;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int REPORT_MAX    = 10;
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_HEAVY    = 77;
  localparam int IDLE_MID      = 38;

  // directed stimulus row, expected result given only where typed is set
  typedef struct packed {
    logic                typed;
    bbss_pkg::out_item_t res;
    bbss_pkg::in_item_t  stim;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b1, '{5'd0, bbss_pkg::OUT_FALLBACK, 32'd0},
      '{bbss_pkg::FUNC_QUERY, 5'd0, 5'd0, 16'h0000}},
    '{1'b1, '{5'd0, bbss_pkg::OUT_APPENDED, 32'd0},
      '{bbss_pkg::FUNC_APPEND, 5'd31, 5'd0, 16'hFFFF}},
    '{1'b1, '{5'd0, bbss_pkg::OUT_APPENDED, 32'd0},
      '{bbss_pkg::FUNC_APPEND, 5'd0, 5'd31, 16'hFFFF}},
    '{1'b0, '0, '{bbss_pkg::FUNC_QUERY, 5'd31, 5'd0, 16'hFFFF}},
    '{1'b1, '{5'd0, bbss_pkg::OUT_APPENDED, 32'd0},
      '{bbss_pkg::FUNC_APPEND, 5'd0, 5'd0, 16'hFFFF}},
    '{1'b1, '{5'd0, bbss_pkg::OUT_CHOSEN, 32'hFFFE0001},
      '{bbss_pkg::FUNC_QUERY, 5'd31, 5'd0, 16'h0000}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd0, 16'h8000}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd31, 16'h0001}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd0, 16'h8000}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd5, 16'hFFFF}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd2, 16'h0000}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd3, 16'h1234}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd4, 16'hFFFF}},
    '{1'b0, '0, '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd31, 16'h0000}},
    '{1'b1, '{5'd0, bbss_pkg::OUT_FULL, 32'd0},
      '{bbss_pkg::FUNC_APPEND, 5'd5, 5'd7, 16'hFFFF}},
    '{1'b0, '0, '{bbss_pkg::FUNC_QUERY, 5'd5, 5'd0, 16'h5555}},
    '{1'b0, '0, '{bbss_pkg::FUNC_QUERY, 5'd5, 5'd31, 16'h0000}},
    '{1'b1, '{5'd0, bbss_pkg::OUT_FALLBACK, 32'd0},
      '{bbss_pkg::FUNC_QUERY, 5'd2, 5'd0, 16'hAAAA}},
    '{1'b0, '0, '{bbss_pkg::FUNC_QUERY, 5'd5, 5'd5, 16'h0000}},
    '{1'b0, '0, '{bbss_pkg::FUNC_QUERY, 5'd31, 5'd31, 16'h0000}}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bbss_pkg::STATE_W-1:0]  cfg_wdata_i;
  logic                          start;
  bbss_pkg::in_item_t            item_i;
  logic                          busy;
  logic                          done_o;
  bbss_pkg::out_item_t           result_o;

  // shadow copy of the transition table and fallback register
  logic [bbss_pkg::STATE_W-1:0]  tgt_tab [NUM_ST][MAX_ENT];
  logic [bbss_pkg::PROB_W-1:0]   wgt_tab [NUM_ST][MAX_ENT];
  int                            list_len [NUM_ST];
  logic [bbss_pkg::STATE_W-1:0]  fallback_sel;

  bbss_pkg::out_item_t           pending_results [$];
  int                            mismatches;
  int                            cycles;

  best_bridge_state_select_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .item_i      (item_i),
    .busy        (busy),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // weight of the first entry of state s aimed at dest, zero if none
  function automatic logic [bbss_pkg::PROB_W-1:0] reach_weight(
      logic [bbss_pkg::STATE_W-1:0] s, logic [bbss_pkg::STATE_W-1:0] dest);
    int k;
    for (k = 0; k < list_len[s]; k++) begin
      if (tgt_tab[s][k] == dest) return wgt_tab[s][k];
    end
    return '0;
  endfunction

  // expected result of one transaction, updating the shadow table
  function automatic bbss_pkg::out_item_t predict_bridge(bbss_pkg::in_item_t it);
    bbss_pkg::out_item_t          r;
    logic [bbss_pkg::SCORE_W-1:0] score;
    logic [bbss_pkg::SCORE_W-1:0] best;
    logic [bbss_pkg::STATE_W-1:0] cand;
    logic [bbss_pkg::STATE_W-1:0] best_state;
    int                           n;
    int                           k;
    r = '0;
    n = list_len[it.from_state];
    if (it.func == bbss_pkg::FUNC_APPEND) begin
      if (n >= MAX_ENT) begin
        r.outcome = bbss_pkg::OUT_FULL;
      end else begin
        tgt_tab[it.from_state][n] = it.to_state;
        wgt_tab[it.from_state][n] = it.probability;
        list_len[it.from_state] = n + 1;
        r.outcome = bbss_pkg::OUT_APPENDED;
      end
    end else if (n == 0) begin
      r.chosen_state = fallback_sel;
      r.outcome = bbss_pkg::OUT_FALLBACK;
    end else begin
      best = '0;
      best_state = '0;
      // strict compare keeps the earliest candidate on ties
      for (k = 0; k < n; k++) begin
        cand = tgt_tab[it.from_state][k];
        score = bbss_pkg::SCORE_W'(wgt_tab[it.from_state][k]) *
                bbss_pkg::SCORE_W'(reach_weight(cand, it.to_state));
        if (score > best) begin
          best = score;
          best_state = cand;
        end
      end
      if (best == '0) begin
        r.chosen_state = it.from_state;
        r.outcome = bbss_pkg::OUT_ORIGIN;
      end else begin
        r.chosen_state = best_state;
        r.outcome = bbss_pkg::OUT_CHOSEN;
        r.best_score = best;
      end
    end
    return r;
  endfunction

  // states mostly from a small pool so that lists chain into each other
  function automatic logic [bbss_pkg::STATE_W-1:0] pick_state();
    if ($urandom_range(99) < 85) return bbss_pkg::STATE_W'($urandom_range(POOL_HI));
    return bbss_pkg::STATE_W'($urandom_range(NUM_ST - 1));
  endfunction

  function automatic bbss_pkg::in_item_t random_item();
    bbss_pkg::in_item_t it;
    int                 roll;
    it.func = ($urandom_range(99) < 45) ? bbss_pkg::FUNC_APPEND : bbss_pkg::FUNC_QUERY;
    it.from_state = pick_state();
    it.to_state = pick_state();
    roll = $urandom_range(9);
    if (roll == 0) it.probability = '0;
    else if (roll == 1) it.probability = '1;
    else it.probability = bbss_pkg::PROB_W'($urandom);
    return it;
  endfunction

  // drive one transaction after a random gap, record its expected result
  task automatic issue(input bbss_pkg::in_item_t it, input int idle_pct,
                       input logic typed, input bbss_pkg::out_item_t typed_res);
    bbss_pkg::out_item_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    r = predict_bridge(it);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
  endtask

  // let all outstanding transactions complete
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_fallback(input logic [bbss_pkg::STATE_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    fallback_sel = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    bbss_pkg::out_item_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: chosen %0d outcome %0d score %h",
                   result_o.chosen_state, result_o.outcome, result_o.best_score);
      end else begin
        want = pending_results.pop_front();
        if (result_o.chosen_state !== want.chosen_state ||
            result_o.outcome !== want.outcome ||
            result_o.best_score !== want.best_score) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: exp chosen %0d outcome %0d score %h, got %0d %0d %h",
                     want.chosen_state, want.outcome, want.best_score,
                     result_o.chosen_state, result_o.outcome, result_o.best_score);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int                           i;
    int                           ph;
    int                           pct;
    logic [bbss_pkg::STATE_W-1:0] fb;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    start = 1'b0;
    item_i = '0;
    mismatches = 0;
    cycles = 0;
    fallback_sel = '0;
    for (i = 0; i < NUM_ST; i++) list_len[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows straight after reset
    for (i = 0; i < DIR_ROWS; i++)
      issue(DIR_TABLE[i].stim, IDLE_NONE, DIR_TABLE[i].typed, DIR_TABLE[i].res);

    // random phases, each setting a fallback value and an idle pattern
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          fb = bbss_pkg::STATE_W'(NUM_ST - 1);
          pct = IDLE_NONE;
        end
        1: begin
          fb = '0;
          pct = IDLE_HEAVY;
        end
        2: begin
          fb = bbss_pkg::STATE_W'($urandom_range(NUM_ST - 1));
          pct = IDLE_MID;
        end
        default: begin
          fb = bbss_pkg::STATE_W'($urandom_range(NUM_ST - 1));
          pct = IDLE_NONE;
        end
      endcase
      write_fallback(fb);
      for (i = 0; i < PHASE_ITEMS; i++) issue(random_item(), pct, 1'b0, '0);
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
